/* rtl/gkc_pkg.sv */
// ----------------------------------------------------------------------------
// gkc_pkg
// Shared types and fixed-point constants of the Gabor kernel coefficient
// generator.
// ----------------------------------------------------------------------------
package gkc_pkg;

  localparam int unsigned VW         = 31;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned REC_W      = 33;
  localparam int unsigned EXP_TERMS  = 12;
  localparam int unsigned TRIG_TERMS = 6;
  localparam int unsigned CELL_LAT   = 3;

  localparam logic [VW-1:0] Q30_ONE = VW'(1) << 30;
  localparam logic [31:0]   PI_Q30  = 32'd3373259426;
  localparam logic [31:0]   LN2_Q32 = 32'd2977044472;

  typedef enum logic [2:0] {
    CFG_HALF_SIZE      = 3'd0,
    CFG_COS_ORIENT     = 3'd1,
    CFG_SIN_ORIENT     = 3'd2,
    CFG_INV_SIGMA_SQ   = 3'd3,
    CFG_ASPECT_SQ      = 3'd4,
    CFG_AMPLITUDE      = 3'd5,
    CFG_INV_WAVELENGTH = 3'd6,
    CFG_PHASE_TURNS    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]         half_size;
    logic signed [15:0] cos_orientation;
    logic signed [15:0] sin_orientation;
    logic [15:0]        inv_sigma_sq;
    logic [15:0]        aspect_sq;
    logic [15:0]        amplitude;
    logic [15:0]        inv_wavelength;
    logic [15:0]        phase_turns;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic        zf;
    logic [4:0]  k;
    logic        neg;
    logic        sel;
    logic [29:0] v;
    logic [29:0] v2;
  } sb_t;

endpackage

/* rtl/gkc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// gkc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module gkc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i,
  output gkc_pkg::cfg_t       cfg_o
);
  import gkc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_HALF_SIZE:      cfg_d.half_size       = cfg_wdata_i[4:0];
        CFG_COS_ORIENT:     cfg_d.cos_orientation = cfg_wdata_i;
        CFG_SIN_ORIENT:     cfg_d.sin_orientation = cfg_wdata_i;
        CFG_INV_SIGMA_SQ:   cfg_d.inv_sigma_sq    = cfg_wdata_i;
        CFG_ASPECT_SQ:      cfg_d.aspect_sq       = cfg_wdata_i;
        CFG_AMPLITUDE:      cfg_d.amplitude       = cfg_wdata_i;
        CFG_INV_WAVELENGTH: cfg_d.inv_wavelength  = cfg_wdata_i;
        CFG_PHASE_TURNS:    cfg_d.phase_turns     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_size       <= 5'd3;
      cfg_q.cos_orientation <= 16'sd32767;
      cfg_q.sin_orientation <= 16'sd0;
      cfg_q.inv_sigma_sq    <= 16'd52245;
      cfg_q.aspect_sq       <= 16'd16384;
      cfg_q.amplitude       <= 16'd8315;
      cfg_q.inv_wavelength  <= 16'd32768;
      cfg_q.phase_turns     <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/gkc_horner_cell.sv */
// ----------------------------------------------------------------------------
// gkc_horner_cell
// One Horner step t' = 1 - ((x * t) >> 30) / n in Q30, three register stages.
// ----------------------------------------------------------------------------
module gkc_horner_cell (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [gkc_pkg::VW-1:0]             x_i,
  input  logic [gkc_pkg::VW-1:0]             t_i,
  input  logic                               sel_i,
  input  logic [gkc_pkg::DIV_W-1:0]          div0_i,
  input  logic [gkc_pkg::REC_W-1:0]          rec0_i,
  input  logic [gkc_pkg::DIV_W-1:0]          div1_i,
  input  logic [gkc_pkg::REC_W-1:0]          rec1_i,
  output logic [gkc_pkg::VW-1:0]             x_o,
  output logic [gkc_pkg::VW-1:0]             t_o,
  output logic                               sel_o
);
  import gkc_pkg::*;

  logic [VW-1:0]     xa_q, xb_q, xc_q;
  logic              sela_q, selb_q, selc_q;
  logic [VW-1:0]     pa_q, pb_q, qb_q, tc_q;
  logic [2*VW-1:0]   prod_a;
  logic [63:0]       prod_b;
  logic [REC_W-1:0]  rec;
  logic [DIV_W-1:0]  div;
  logic [38:0]       qn, rem;
  logic [VW-1:0]     qf;

  assign prod_a = (2*VW)'(x_i) * (2*VW)'(t_i);
  assign rec    = sela_q ? rec1_i : rec0_i;
  assign prod_b = 64'(pa_q) * 64'(rec);
  assign div    = selb_q ? div1_i : div0_i;
  assign qn     = 39'(qb_q) * 39'(div);
  assign rem    = 39'(pb_q) - qn;
  assign qf     = qb_q + VW'(rem >= 39'(div));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q   <= x_i;
      sela_q <= sel_i;
      pa_q   <= prod_a[60:30];
      xb_q   <= xa_q;
      selb_q <= sela_q;
      pb_q   <= pa_q;
      qb_q   <= prod_b[62:32];
      xc_q   <= xb_q;
      selc_q <= selb_q;
      tc_q   <= Q30_ONE - qf;
    end
  end

  assign x_o   = xc_q;
  assign t_o   = tc_q;
  assign sel_o = selc_q;

endmodule

/* rtl/gabor_kernel_coefficient.sv */
// ----------------------------------------------------------------------------
// gabor_kernel_coefficient
// Pipelined Gabor kernel coefficient generator: rotation, Gaussian envelope
// by range reduction and a row of Horner cells, cosine carrier likewise.
//
//   channel   dir  tdata (low bit up)            tuser
//   s_axis    in   row[5:0] col[11:6]            -
//   m_axis    out  coefficient[16:0]             position_error
//   cfg       in   index cfg_addr_i, cfg_wdata_i -
//
// One word per cycle while the output is taken; 7 setup stages, 12 exp
// cells of 3 stages each, 3 output stages. The 6 cosine/sine cells run
// beside the last 6 exp cells. The whole pipe holds while the output word
// is not taken. Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module gabor_kernel_coefficient (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // row[5:0], col[11:6]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // coefficient[16:0]
  output logic        m_axis_tuser,   // position_error
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import gkc_pkg::*;

  localparam int unsigned CHAIN_LEN = EXP_TERMS * CELL_LAT;
  localparam int unsigned TRIG_TAP  = (EXP_TERMS - TRIG_TERMS) * CELL_LAT - 1;

  cfg_t cfg;
  logic en;

  gkc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i, .cfg_o(cfg)
  );

  logic [6:1] pv_q;
  logic [6:1] err_q;

  // stage 1
  logic [5:0]        row, col;
  logic signed [6:0] dc_q, dr_q;
  assign row = s_axis_tdata[5:0];
  assign col = s_axis_tdata[11:6];

  // stage 2
  logic signed [22:0] tx_q, ty_q;
  // stage 3
  logic [21:0]        ax, ay;
  logic [43:0]        ax2_q, ay2_q;
  logic signed [39:0] ang_p;
  logic [30:0]        ang_q;
  assign ax    = 22'(tx_q[22] ? -tx_q : tx_q);
  assign ay    = 22'(ty_q[22] ? -ty_q : ty_q);
  assign ang_p = 40'(tx_q) * 40'($signed({1'b0, cfg.inv_wavelength}));

  // stage 4
  logic [59:0] ayg_p;
  logic [43:0] ax2_4_q, ayg_q;
  logic        gt;
  logic [28:0] w;
  logic [60:0] v_p;
  logic [29:0] v4_q;
  logic        sel4_q, neg4_q;
  assign ayg_p = 60'(ay2_q) * 60'(cfg.aspect_sq);
  assign gt    = ang_q[28:0] > (29'd1 << 28);
  assign w     = gt ? (29'(30'd1 << 29) - ang_q[28:0]) : ang_q[28:0];
  assign v_p   = 61'(w) * 61'(PI_Q30);

  // stage 5
  logic [44:0] sum;
  logic [60:0] e_p;
  logic [59:0] vv_p;
  logic [45:0] e5_q;
  logic [29:0] v5_q, v25_q;
  logic        sel5_q, neg5_q;
  assign sum  = 45'(ax2_4_q) + 45'(ayg_q);
  assign e_p  = 61'(sum) * 61'(cfg.inv_sigma_sq);
  assign vv_p = 60'(v4_q) * 60'(v4_q);

  // stage 6
  logic [4:0]  kcnt;
  logic [45:0] e6_q;
  logic [4:0]  k6_q;
  logic        zf6_q, sel6_q, neg6_q;
  logic [29:0] v6_q, v26_q;
  always_comb begin
    kcnt = '0;
    for (int j = 1; j <= 30; j++) begin
      if (e5_q >= 46'(j) * 46'(LN2_Q32)) kcnt = kcnt + 5'd1;
    end
  end

  // stage 7
  logic [45:0] red;
  logic [29:0] r7_q;
  sb_t         s7_q;
  assign red = e6_q - 46'(k6_q) * 46'(LN2_Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[5:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q   <= {err_q[5:1], (row > {cfg.half_size, 1'b0}) || (col > {cfg.half_size, 1'b0})};
      dc_q    <= $signed({1'b0, col}) - $signed({2'b0, cfg.half_size});
      dr_q    <= $signed({1'b0, row}) - $signed({2'b0, cfg.half_size});
      tx_q    <= 23'(dc_q) * 23'(cfg.cos_orientation) + 23'(dr_q) * 23'(cfg.sin_orientation);
      ty_q    <= 23'(dr_q) * 23'(cfg.cos_orientation) - 23'(dc_q) * 23'(cfg.sin_orientation);
      ax2_q   <= 44'(ax) * 44'(ax);
      ay2_q   <= 44'(ay) * 44'(ay);
      ang_q   <= ang_p[30:0] + {cfg.phase_turns, 15'd0};
      ax2_4_q <= ax2_q;
      ayg_q   <= ayg_p[59:16];
      v4_q    <= v_p[59:30];
      sel4_q  <= ang_q[29] ^ gt;
      neg4_q  <= ang_q[30] ^ ang_q[29];
      e5_q    <= e_p[60:15];
      v5_q    <= v4_q;
      v25_q   <= vv_p[59:30];
      sel5_q  <= sel4_q;
      neg5_q  <= neg4_q;
      e6_q    <= e5_q;
      k6_q    <= kcnt;
      zf6_q   <= e5_q >= 46'(31) * 46'(LN2_Q32);
      v6_q    <= v5_q;
      v26_q   <= v25_q;
      sel6_q  <= sel5_q;
      neg6_q  <= neg5_q;
      r7_q    <= red[31:2];
      s7_q    <= '{valid: pv_q[6], err: err_q[6], zf: zf6_q, k: k6_q, neg: neg6_q,
                   sel: sel6_q, v: v6_q, v2: v26_q};
    end
  end

  // sideband shift line beside the cell row
  sb_t sb_q [CHAIN_LEN];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CHAIN_LEN; j++) sb_q[j] <= '0;
    end else if (en) begin
      sb_q[0] <= s7_q;
      for (int j = 1; j < CHAIN_LEN; j++) sb_q[j] <= sb_q[j-1];
    end
  end

  // exp cells
  logic [VW-1:0] ex_x [EXP_TERMS+1];
  logic [VW-1:0] ex_t [EXP_TERMS+1];
  logic          ex_s [EXP_TERMS+1];
  assign ex_x[0] = VW'(r7_q);
  assign ex_t[0] = Q30_ONE;
  assign ex_s[0] = 1'b0;

  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
    localparam int unsigned N = EXP_TERMS - i;
    localparam logic [REC_W-1:0] REC = REC_W'((64'd1 << 32) / N);
    gkc_horner_cell u_cell (
      .clk_i, .en_i(en), .x_i(ex_x[i]), .t_i(ex_t[i]), .sel_i(ex_s[i]),
      .div0_i(DIV_W'(N)), .rec0_i(REC), .div1_i(DIV_W'(N)), .rec1_i(REC),
      .x_o(ex_x[i+1]), .t_o(ex_t[i+1]), .sel_o(ex_s[i+1])
    );
  end

  // cosine / sine cells
  logic [VW-1:0] tr_x [TRIG_TERMS+1];
  logic [VW-1:0] tr_t [TRIG_TERMS+1];
  logic          tr_s [TRIG_TERMS+1];
  assign tr_x[0] = VW'(sb_q[TRIG_TAP].v2);
  assign tr_t[0] = Q30_ONE;
  assign tr_s[0] = sb_q[TRIG_TAP].sel;

  for (genvar i = 0; i < TRIG_TERMS; i++) begin : g_trig
    localparam int unsigned K  = TRIG_TERMS - i;
    localparam int unsigned DC = (2 * K) * (2 * K - 1);
    localparam int unsigned DS = (2 * K) * (2 * K + 1);
    localparam logic [REC_W-1:0] RECC = REC_W'((64'd1 << 32) / DC);
    localparam logic [REC_W-1:0] RECS = REC_W'((64'd1 << 32) / DS);
    gkc_horner_cell u_cell (
      .clk_i, .en_i(en), .x_i(tr_x[i]), .t_i(tr_t[i]), .sel_i(tr_s[i]),
      .div0_i(DIV_W'(DC)), .rec0_i(RECC), .div1_i(DIV_W'(DS)), .rec1_i(RECS),
      .x_o(tr_x[i+1]), .t_o(tr_t[i+1]), .sel_o(tr_s[i+1])
    );
  end

  // output stages
  sb_t           sbe;
  logic [60:0]   sin_p;
  logic          f1v_q, f1e_q, f1n_q, f2v_q, f2e_q, f2n_q;
  logic [VW-1:0] ex1_q, mag1_q, mag2_q, m2_q;
  logic [46:0]   am_p;
  logic [62:0]   fin_p;
  logic [18:0]   rmag;
  logic [16:0]   coef_d, coef_q;
  logic          out_v_q, perr_q;

  assign sbe   = sb_q[CHAIN_LEN-1];
  assign sin_p = 61'(sbe.v) * 61'(tr_t[TRIG_TERMS]);
  assign am_p  = 47'(cfg.amplitude) * 47'(ex1_q);
  assign fin_p = 63'(m2_q) * 63'(mag2_q) + (63'(1) << 43);
  assign rmag  = fin_p[62:44];

  always_comb begin
    if (f2e_q) begin
      coef_d = '0;
    end else if (f2n_q) begin
      coef_d = 17'(-(rmag > 19'd65536 ? 19'd65536 : rmag));
    end else begin
      coef_d = 17'(rmag > 19'd65535 ? 19'd65535 : rmag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1v_q   <= 1'b0;
      f2v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      f1v_q   <= sbe.valid;
      f2v_q   <= f1v_q;
      out_v_q <= f2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1e_q  <= sbe.err;
      f1n_q  <= sbe.neg;
      ex1_q  <= sbe.zf ? '0 : (ex_t[EXP_TERMS] >> sbe.k);
      mag1_q <= tr_s[TRIG_TERMS] ? sin_p[60:30] : tr_t[TRIG_TERMS];
      f2e_q  <= f1e_q;
      f2n_q  <= f1n_q;
      m2_q   <= am_p[46:16];
      mag2_q <= mag1_q;
      coef_q <= coef_d;
      perr_q <= f2e_q;
    end
  end

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, coef_q};
  assign m_axis_tuser  = perr_q;

endmodule
